// ----- rtl/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg - shared types and constants of the first-fit heap allocator
// Operation and status codes, sequencer states and the header store command.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

	// default heap size in bytes
	localparam int unsigned HeapBytesDef = 65520;

	// walk position width: an offset plus a block size still fits
	localparam int unsigned PosW  = 17;
	localparam int unsigned HdrW  = 16;
	localparam int unsigned HdrBytes = 4;

	typedef enum logic [1:0] {
		FN_ALLOC = 2'd0,
		FN_FREE  = 2'd1,
		FN_CHECK = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOSPACE  = 3'd1,
		ST_ZERO     = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_CORRUPT  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_SPLIT,
		S_FREE_RD,
		S_FREE_NXT,
		S_DONE
	} fsm_state_t;

	// command to the header store
	typedef struct packed {
		logic            rd_en;
		logic            wr_en;
		logic [HdrW-1:0] wr_data;
	} hdr_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator - first-fit boundary-tag heap allocator
// Allocate, free and check requests against one heap kept as a chain of
// block headers in an on-chip store.
// ----------------------------------------------------------------------------
// The heap is a chain of blocks, each led by a 4-byte header holding the
// even payload size with bit 0 as the free mark; the headers live in a
// single-port-per-direction store of HEAP_BYTES/2 words with a registered
// read. Every request but a zero-size allocate or an unused opcode walks
// the chain from offset 0, one header per cycle: the header of the next
// block is fetched in the same cycle that the current one is examined. An
// allocate ends with the walk, or with a write of the remainder header when
// the found block is split; a free that finds its offset then reads the next
// header and writes the merged header, or writes at once when the freed
// block is the last in the heap. The result sits in an output register, so
// the next word is taken while it waits.
// After reset a clearing pass initialises the store; no word is taken until
// it is done. Status codes: 0 ok, 1 no space, 2 zero size, 3 offset not
// found, 4 heap corrupt; the payload offset is 0 unless an allocate succeeds.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator #(
	parameter int unsigned HEAP_BYTES = ffha_pkg::HeapBytesDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [15:0] req_size, [31:16] free_offset
	input  wire logic [1:0]  s_tuser,   // [1:0] func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [15:0] payload_offset
	output logic [2:0]       m_tuser    // [2:0] status
);
	import ffha_pkg::*;

	localparam int unsigned HeapLen = HEAP_BYTES & 32'hFFFE;
	localparam int unsigned AddrW   = $clog2(HeapLen / 2);
	localparam logic [PosW-1:0] HeapLenW = PosW'(HeapLen);
	localparam logic [PosW-1:0] HdrStep  = PosW'(HdrBytes);

	// sequencer state and per-request registers
	fsm_state_t       state_q, state_d;
	logic [1:0]       op_q;
	logic [PosW-1:0]  want_q;
	logic [15:0]      target_q;
	logic [PosW-1:0]  pos_q;
	logic [PosW-1:0]  prev_q;
	logic [HdrW-1:0]  prev_hdr_q;
	logic             have_prev_q;
	logic [PosW-1:0]  base_q;
	logic [HdrW-1:0]  base_size_q;
	logic [PosW-1:0]  split_pos_q;
	logic [HdrW-1:0]  split_val_q;
	status_t          res_status_q;
	logic [15:0]      res_payload_q;

	// output register
	logic             m_tvalid_q;
	logic [2:0]       m_tuser_q;
	logic [15:0]      m_tdata_q;

	// header store
	hdr_cmd_t         cmd;
	logic [AddrW-1:0] rd_addr;
	logic [AddrW-1:0] wr_addr;
	logic [HdrW-1:0]  hdr;
	logic             mem_ready;

	// datapath
	logic             accept;
	logic             out_free;
	logic [PosW-1:0]  want_in;
	logic [HdrW-1:0]  cur_size;
	logic             cur_free;
	logic [PosW-1:0]  step_pos;
	logic             step_end;
	logic             fit;
	logic [PosW-1:0]  spare;
	logic [PosW-1:0]  spare_m4;
	logic             do_split;
	logic [PosW-1:0]  split_pos;
	logic [HdrW-1:0]  alloc_hdr;
	logic             hit;
	logic [HdrW-1:0]  prev_size;
	logic             prev_free;
	logic [HdrW-1:0]  merged_size;
	logic [PosW-1:0]  nxt_pos;
	logic             nxt_in;
	logic [HdrW-1:0]  fin_size;
	logic             res_set;
	status_t          res_status_d;
	logic [15:0]      res_payload_d;

	ffha_hdr_mem #(
		.HEAP_BYTES (HEAP_BYTES)
	) u_hdr_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.rd_data (hdr),
		.ready   (mem_ready)
	);

	assign s_tready = (state_q == S_IDLE) && mem_ready;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// odd request sizes round up to even
	assign want_in  = {1'b0, s_tdata[15:0]} + PosW'(s_tdata[0]);

	// header under examination (read issued the cycle before)
	assign cur_size = {hdr[HdrW-1:1], 1'b0};
	assign cur_free = hdr[0];
	assign step_pos = pos_q + PosW'(cur_size) + HdrStep;
	assign step_end = step_pos >= HeapLenW;

	// allocate: first fit, split when more than a header would remain
	assign fit       = cur_free && ({1'b0, cur_size} >= want_q);
	assign spare     = {1'b0, cur_size} - want_q;
	assign spare_m4  = spare - HdrStep;
	assign do_split  = spare > HdrStep;
	assign split_pos = pos_q + HdrStep + want_q;
	assign alloc_hdr = do_split ? want_q[HdrW-1:0] : cur_size;

	// free: match on payload offset, fold into a free previous block and swallow a free next block
	assign hit         = (pos_q + HdrStep) == {1'b0, target_q};
	assign prev_size   = {prev_hdr_q[HdrW-1:1], 1'b0};
	assign prev_free   = have_prev_q && prev_hdr_q[0];
	assign merged_size = prev_size + cur_size + HdrW'(HdrBytes);
	assign nxt_pos     = base_q + PosW'(base_size_q) + HdrStep;
	assign nxt_in      = nxt_pos < HeapLenW;
	assign fin_size    = cur_free ? (base_size_q + cur_size + HdrW'(HdrBytes)) : base_size_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (s_tuser == FN_ALLOC && want_in == '0) begin
						state_d = S_DONE;
					end else if (s_tuser == FN_ALLOC || s_tuser == FN_FREE ||
					             s_tuser == FN_CHECK) begin
						state_d = S_WALK;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_WALK: begin
				case (op_q)
					FN_ALLOC: begin
						if (fit) begin
							state_d = do_split ? S_SPLIT : S_DONE;
						end else if (step_end) begin
							state_d = S_DONE;
						end
					end
					FN_FREE: begin
						if (hit) begin
							state_d = S_FREE_RD;
						end else if (step_end) begin
							state_d = S_DONE;
						end
					end
					FN_CHECK: begin
						if (step_end) begin
							state_d = S_DONE;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_SPLIT:    state_d = S_DONE;
			S_FREE_RD:  state_d = nxt_in ? S_FREE_NXT : S_DONE;
			S_FREE_NXT: state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// store accesses and result
	always_comb begin
		cmd           = '0;
		rd_addr       = '0;
		wr_addr       = '0;
		res_set       = 1'b0;
		res_status_d  = ST_OK;
		res_payload_d = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (s_tuser == FN_ALLOC && want_in == '0) begin
						res_set      = 1'b1;
						res_status_d = ST_ZERO;
					end else if (s_tuser == FN_ALLOC || s_tuser == FN_FREE ||
					             s_tuser == FN_CHECK) begin
						cmd.rd_en = 1'b1;
					end else begin
						res_set = 1'b1;
					end
				end
			end
			S_WALK: begin
				rd_addr = step_pos[AddrW:1];
				wr_addr = pos_q[AddrW:1];
				case (op_q)
					FN_ALLOC: begin
						if (fit) begin
							cmd.wr_en     = 1'b1;
							cmd.wr_data   = alloc_hdr;
							res_set       = 1'b1;
							res_payload_d = pos_q[15:0] + 16'(HdrBytes);
						end else if (step_end) begin
							res_set      = 1'b1;
							res_status_d = ST_NOSPACE;
						end else begin
							cmd.rd_en = 1'b1;
						end
					end
					FN_FREE: begin
						if (!hit) begin
							if (step_end) begin
								res_set      = 1'b1;
								res_status_d = ST_NOTFOUND;
							end else begin
								cmd.rd_en = 1'b1;
							end
						end
					end
					FN_CHECK: begin
						if (step_end) begin
							res_set      = 1'b1;
							res_status_d = (step_pos == HeapLenW) ? ST_OK : ST_CORRUPT;
						end else begin
							cmd.rd_en = 1'b1;
						end
					end
					default: res_set = 1'b1;
				endcase
			end
			S_SPLIT: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_data = split_val_q;
				wr_addr     = split_pos_q[AddrW:1];
			end
			S_FREE_RD: begin
				rd_addr = nxt_pos[AddrW:1];
				wr_addr = base_q[AddrW:1];
				res_set = 1'b1;
				if (nxt_in) begin
					cmd.rd_en = 1'b1;
				end else begin
					cmd.wr_en   = 1'b1;
					cmd.wr_data = {base_size_q[HdrW-1:1], 1'b1};
				end
			end
			S_FREE_NXT: begin
				wr_addr     = base_q[AddrW:1];
				cmd.wr_en   = 1'b1;
				cmd.wr_data = {fin_size[HdrW-1:1], 1'b1};
			end
			S_DONE: ;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			have_prev_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				have_prev_q <= 1'b0;
			end else if (state_q == S_WALK) begin
				have_prev_q <= 1'b1;
			end
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= s_tuser;
			want_q   <= want_in;
			target_q <= s_tdata[31:16];
			pos_q    <= '0;
		end
		if (state_q == S_WALK) begin
			pos_q      <= step_pos;
			prev_q     <= pos_q;
			prev_hdr_q <= hdr;
		end
		// remainder of a split block becomes a new free header
		split_pos_q <= split_pos;
		split_val_q <= {spare_m4[HdrW-1:1], 1'b1};
		if (state_q == S_WALK && hit) begin
			base_q      <= prev_free ? prev_q : pos_q;
			base_size_q <= prev_free ? {merged_size[HdrW-1:1], 1'b0} : cur_size;
		end
		if (res_set) begin
			res_status_q  <= res_status_d;
			res_payload_q <= res_payload_d;
		end
		if (state_q == S_DONE && out_free) begin
			m_tuser_q <= res_status_q;
			m_tdata_q <= res_payload_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	// one store access a cycle, so a read never races a write
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd_en && cmd.wr_en))
		else $error("header store read and write in the same cycle");

	// a walk only ever looks at headers inside the heap
	a_walk_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> pos_q < HeapLenW)
		else $error("walk position beyond heap end");

	// an accepted word always leaves the idle state
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted word did not start a request");

	// a finished request lands in the output register
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_free |=> m_tvalid_q && state_q == S_IDLE)
		else $error("result not delivered to output register");
`endif

endmodule

`default_nettype wire

// ----- rtl/ffha_hdr_mem.sv -----
// ----------------------------------------------------------------------------
// ffha_hdr_mem - block header store
// One 16-bit word per even heap offset, one write and one registered read a
// cycle. After reset a sweep writes every entry, entry 0 as one free block.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_hdr_mem #(
	parameter int unsigned HEAP_BYTES = ffha_pkg::HeapBytesDef,
	localparam int unsigned AddrW = $clog2((HEAP_BYTES & 32'hFFFE) / 2)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ffha_pkg::hdr_cmd_t cmd,
	input  wire logic [AddrW-1:0]   rd_addr,
	input  wire logic [AddrW-1:0]   wr_addr,
	output logic [ffha_pkg::HdrW-1:0] rd_data,
	output logic                    ready
);
	import ffha_pkg::*;

	localparam int unsigned HeapLen = HEAP_BYTES & 32'hFFFE;
	localparam int unsigned Depth   = HeapLen / 2;
	localparam logic [HdrW-1:0] InitHdr = HdrW'((HeapLen - HdrBytes) & 32'hFFFE) | HdrW'(1);

	logic [HdrW-1:0]  mem [Depth];
	logic [AddrW-1:0] clr_cnt_q;
	logic             clr_busy_q;
	logic             we;
	logic [AddrW-1:0] wa;
	logic [HdrW-1:0]  wd;
	logic [HdrW-1:0]  rd_q;

	// clearing sweep, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + AddrW'(1);
			if (clr_cnt_q == AddrW'(Depth - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (clr_busy_q) begin
			we = 1'b1;
			wa = clr_cnt_q;
			wd = (clr_cnt_q == '0) ? InitHdr : '0;
		end else begin
			we = cmd.wr_en;
			wa = wr_addr;
			wd = cmd.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
	assign ready   = !clr_busy_q;

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the first-fit heap allocator
// Drives allocate, free and check words into the stream input, keeps its own
// model of the header chain, and compares every result word, status and
// payload offset, against the model's prediction in order of arrival.
// ----------------------------------------------------------------------------

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ffha_pkg::*;

	// heap geometry as the block sees it at the default size
	localparam int unsigned HeapLen  = HeapBytesDef & 32'hFFFE;
	localparam int unsigned HdrDepth = HeapLen / 2;

	// the opcode that the package leaves unnamed; the block must ignore it
	localparam logic [1:0] FnUnused = 2'd3;

	localparam int unsigned PhaseItems = 250;  // random words per idling phase
	localparam int unsigned LiveCap    = 40;   // keeps the chain, and so the walks, short
	localparam int unsigned QueueDepth = 4;    // words queued ahead of the sender
	localparam int unsigned HoldCycles = 500;  // long receiver hold-off
	localparam int unsigned TailCycles = 200;  // quiet time after the last result

	typedef struct packed {
		logic [1:0]  fn;
		logic [15:0] req;
		logic [15:0] target;
	} heap_op_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] payload;
	} heap_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [15:0] req_size, [31:16] free_offset
	logic [1:0]  s_tuser = '0;   // [1:0] func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [15:0] payload_offset
	logic [2:0]  m_tuser;        // [2:0] status

	first_fit_heap_allocator #(
		.HEAP_BYTES(HeapBytesDef)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// model state: one header word per even byte offset
	logic [15:0] hdr_store [HdrDepth];

	heap_op_t    pending_ops [$];     // words waiting for the sender
	heap_reply_t owed_replies [$];    // predicted results, oldest first
	logic [15:0] live_payloads [$];   // payloads currently allocated in the model
	logic [15:0] last_freed = '0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	logic        rx_hold = 1'b0;
	logic        in_taken = 1'b0;     // input word accepted at the last rising edge
	event        hold_go;

	int unsigned fault_count = 0;
	int unsigned words_in = 0, words_out = 0;
	int unsigned n_grant = 0, n_release = 0, n_nospace = 0, n_notfound = 0;
	int unsigned n_zero = 0, n_walk = 0;

	// ---- header chain model ------------------------------------------------

	// accesses beyond the store read as zero and drop writes
	function automatic logic [15:0] hdr_word(int unsigned pos);
		if ((pos >> 1) < HdrDepth)
			return hdr_store[pos >> 1];
		return '0;
	endfunction

	function automatic void hdr_put(int unsigned pos, logic [15:0] val);
		if ((pos >> 1) < HdrDepth)
			hdr_store[pos >> 1] = val;
	endfunction

	function automatic int unsigned blk_bytes(int unsigned pos);
		return int'(hdr_word(pos) & 16'hFFFE);
	endfunction

	function automatic bit blk_is_free(int unsigned pos);
		logic [15:0] h;
		h = hdr_word(pos);
		return h[0];
	endfunction

	// new size, free mark kept
	function automatic void blk_resize(int unsigned pos, int unsigned size);
		hdr_put(pos, (16'(size) & 16'hFFFE) | (hdr_word(pos) & 16'd1));
	endfunction

	// applies one request word to the model chain and returns its result
	function automatic heap_reply_t heap_apply(logic [1:0] fn, logic [15:0] req,
			logic [15:0] target);
		heap_reply_t rep;
		int unsigned want, pos, size, prev, nxt;
		bit have_prev;
		rep.status  = ST_OK;
		rep.payload = '0;
		pos = 0;
		case (fn)
			FN_ALLOC: begin
				// odd sizes round up to even
				want = req + req[0];
				if (want == 0) begin
					rep.status = ST_ZERO;
				end else begin
					rep.status = ST_NOSPACE;
					while (pos < HeapLen && rep.status == ST_NOSPACE) begin
						size = blk_bytes(pos);
						if (size >= want && blk_is_free(pos)) begin
							// split only when more than a bare header is left
							if (size - want > HdrBytes) begin
								hdr_put(pos + HdrBytes + want,
									16'(size - want - HdrBytes) | 16'd1);
								size = want;
							end
							hdr_put(pos, 16'(size));   // even size, free mark cleared
							rep.status  = ST_OK;
							rep.payload = 16'(pos + HdrBytes);
						end else begin
							pos += size + HdrBytes;
						end
					end
				end
			end
			FN_FREE: begin
				rep.status = ST_NOTFOUND;
				prev = 0;
				have_prev = 1'b0;
				while (pos < HeapLen && rep.status == ST_NOTFOUND) begin
					if (pos + HdrBytes == int'(target)) begin
						// fold into a free predecessor, then swallow a free successor
						if (have_prev && blk_is_free(prev)) begin
							blk_resize(prev, blk_bytes(prev) + blk_bytes(pos) + HdrBytes);
							pos = prev;
						end
						nxt = pos + blk_bytes(pos) + HdrBytes;
						if (nxt < HeapLen && blk_is_free(nxt))
							blk_resize(pos, blk_bytes(pos) + blk_bytes(nxt) + HdrBytes);
						hdr_put(pos, hdr_word(pos) | 16'd1);
						rep.status = ST_OK;
					end else begin
						prev = pos;
						have_prev = 1'b1;
						pos += blk_bytes(pos) + HdrBytes;
					end
				end
			end
			FN_CHECK: begin
				while (pos < HeapLen)
					pos += blk_bytes(pos) + HdrBytes;
				if (pos != HeapLen)
					rep.status = ST_CORRUPT;
			end
			default: ;
		endcase
		return rep;
	endfunction

	// ---- sender ------------------------------------------------------------

	// a word stays on the bus until taken; only then may the next one, or a gap,
	// follow. Idle cycles carry junk so that the block must qualify by tvalid.
	always @(negedge clk) begin : sender
		heap_op_t op;
		if (!s_tvalid || in_taken) begin
			if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				op = pending_ops.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= op.fn;
				s_tdata  <= {op.target, op.req};
			end else begin
				s_tvalid <= 1'b0;
				s_tuser  <= 2'($urandom);
				s_tdata  <= $urandom;
			end
		end
	end

	// ---- receiver ----------------------------------------------------------

	always @(negedge clk)
		m_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);

	// long hold-off, counted here so the sender keeps pushing meanwhile
	always begin : long_stall
		@(hold_go);
		rx_hold = 1'b1;
		repeat (HoldCycles) @(posedge clk);
		rx_hold = 1'b0;
	end

	// ---- monitor and checker -----------------------------------------------

	always @(posedge clk or negedge arst_n) begin : monitor
		heap_reply_t predicted, owed;
		int unsigned i;
		if (!arst_n) begin
			// one free block spanning the whole heap
			for (i = 0; i < HdrDepth; i++)
				hdr_store[i] = '0;
			hdr_put(0, 16'(HeapLen - HdrBytes) | 16'd1);
			in_taken <= 1'b0;
		end else begin
			in_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				predicted = heap_apply(s_tuser, s_tdata[15:0], s_tdata[31:16]);
				owed_replies.push_back(predicted);
				words_in++;
				case (predicted.status)
					ST_NOSPACE:  n_nospace++;
					ST_NOTFOUND: n_notfound++;
					ST_ZERO:     n_zero++;
					default: ;
				endcase
				if (s_tuser == FN_CHECK)
					n_walk++;
				// keep the list of live payloads in step with the model
				if (s_tuser == FN_ALLOC && predicted.status == ST_OK) begin
					live_payloads.push_back(predicted.payload);
					n_grant++;
				end
				if (s_tuser == FN_FREE && predicted.status == ST_OK) begin
					for (i = 0; i < live_payloads.size(); i++)
						if (live_payloads[i] == s_tdata[31:16]) begin
							live_payloads.delete(i);
							break;
						end
					last_freed = s_tdata[31:16];
					n_release++;
				end
			end
			if (m_tvalid && m_tready) begin
				if (owed_replies.size() == 0) begin
					$error("result word with nothing outstanding: status %0d, payload %0d",
						m_tuser, m_tdata);
					fault_count++;
				end else begin
					owed = owed_replies.pop_front();
					words_out++;
					if (m_tuser !== owed.status) begin
						$error("status mismatch: expected %0d, got %0d", owed.status, m_tuser);
						fault_count++;
					end
					if (m_tdata !== owed.payload) begin
						$error("payload_offset mismatch: expected %0d, got %0d",
							owed.payload, m_tdata);
						fault_count++;
					end
				end
			end
		end
	end

	// ---- stimulus ----------------------------------------------------------

	// settle point just after a rising edge, clear of the monitor's updates
	task automatic next_slot();
		@(posedge clk);
		#1;
	endtask

	// the operand that the opcode ignores carries junk
	function automatic void queue_op(logic [1:0] fn, int unsigned arg);
		heap_op_t op;
		op.fn     = fn;
		op.req    = (fn == FN_ALLOC) ? 16'(arg) : 16'($urandom);
		op.target = (fn == FN_FREE) ? 16'(arg) : 16'($urandom);
		pending_ops.push_back(op);
	endfunction

	task automatic wait_drained();
		while (pending_ops.size() != 0 || s_tvalid || owed_replies.size() != 0)
			next_slot();
	endtask

	task automatic run_phase(int unsigned send_pct, int unsigned stall_pct, bit long_hold);
		int unsigned n, pick, live_n;
		logic [15:0] pal;
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		for (n = 0; n < PhaseItems; n++) begin
			while (pending_ops.size() >= QueueDepth)
				next_slot();
			if (long_hold && n == 8)
				-> hold_go;
			live_n = live_payloads.size();
			pal = (live_n != 0) ? live_payloads[$urandom_range(live_n - 1)] : 16'($urandom);
			// mostly proper alloc/free traffic; frees grow likelier as the heap fills
			if (live_n >= LiveCap || (live_n != 0 && $urandom_range(99) < 20 + live_n)) begin
				queue_op(FN_FREE, pal);
			end else begin
				pick = $urandom_range(99);
				if (pick < 50)
					queue_op(FN_ALLOC, $urandom_range(400, 1));
				else if (pick < 65)
					queue_op(FN_ALLOC, $urandom_range(6000, 401));
				else if (pick < 70)
					queue_op(FN_ALLOC, $urandom_range(HeapBytesDef, 6001));
				else if (pick < 73)
					queue_op(FN_ALLOC, 0);
				else if (pick < 80)
					queue_op(FN_FREE, $urandom_range(16'hFFFF));
				else if (pick < 84)
					queue_op(FN_FREE, last_freed);   // often a block already free
				else if (pick < 88)
					queue_op(FN_FREE, pal + 16'd2);  // inside a block, not its start
				else if (pick < 95)
					queue_op(FN_CHECK, 0);
				else
					queue_op(FnUnused, 0);
			end
		end
		// sender stands back until every result is home
		wait_drained();
	endtask

	initial begin : stimulus
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed words on the fresh heap; the clearing pass holds them back
		queue_op(FN_CHECK, 0);
		queue_op(FN_ALLOC, 0);              // zero size
		queue_op(FN_ALLOC, HeapBytesDef);   // larger than the heap
		queue_op(FN_FREE, 0);               // offset zero is no payload
		queue_op(FN_FREE, 16'hFFFF);
		queue_op(FnUnused, 0);
		queue_op(FN_ALLOC, 65515);          // odd, rounds up to an exact fit
		queue_op(FN_ALLOC, 1);              // heap full
		queue_op(FN_CHECK, 0);
		queue_op(FN_FREE, 4);
		queue_op(FN_FREE, 4);               // already free
		queue_op(FN_ALLOC, 1);
		queue_op(FN_ALLOC, 3);
		queue_op(FN_ALLOC, 100);
		queue_op(FN_ALLOC, 65394);          // leaves exactly a header: no split
		queue_op(FN_CHECK, 0);
		queue_op(FN_FREE, 10);              // both neighbours in use
		queue_op(FN_FREE, 4);               // swallows the free successor
		queue_op(FN_FREE, 122);             // last block in the chain
		queue_op(FN_FREE, 18);              // merges on both sides
		queue_op(FN_FREE, 11);
		queue_op(FN_ALLOC, 32768);
		queue_op(FN_FREE, 32776);           // the free remainder
		queue_op(FN_FREE, 4);
		queue_op(FN_CHECK, 0);
		wait_drained();

		run_phase(0, 0, 1'b1);
		run_phase(81, 0, 1'b0);
		run_phase(0, 81, 1'b0);
		run_phase(22, 22, 1'b0);

		repeat (TailCycles) @(posedge clk);
		$display("covered %0d words in, %0d results checked: %0d grants, %0d releases,",
			words_in, words_out, n_grant, n_release);
		$display("  %0d out of space, %0d unknown offsets, %0d zero sizes, %0d chain checks",
			n_nospace, n_notfound, n_zero, n_walk);
		if (fault_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog, well beyond the slowest legal run
	initial begin : watchdog
		#10ms;
		$display("status: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/ffha_pkg.sv
rtl/ffha_hdr_mem.sv
rtl/first_fit_heap_allocator.sv
test/testbench.sv
